// ===== hdl/tws_pkg.sv =====
// tws_pkg: shared types, codes and helpers of the time window schedule table
// no dependencies; imported by the channel users, the window unit and the top level

package tws_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int HOUR_W          = 5;
   localparam int MINUTE_W        = 6;
   localparam int DAYMIN_W        = 11;

   localparam logic CMD_QUERY = 1'b0;
   localparam logic CMD_STORE = 1'b1;

   typedef struct packed {
      logic                command;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [HOUR_W-1:0]   end_hour;
      logic [MINUTE_W-1:0] end_minute;
      logic                window_state;
   } req_type;

   typedef struct packed {
      logic output_on;
      logic stored;
   } rsp_type;

   typedef struct packed {
      logic [HOUR_W-1:0]   start_hour;
      logic [MINUTE_W-1:0] start_minute;
      logic [HOUR_W-1:0]   end_hour;
      logic [MINUTE_W-1:0] end_minute;
      logic                state;
   } window_type;

   typedef struct packed {
      logic ordered;
      logic in_window;
   } cmp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // hour * 60 + minute as (hour << 6) - (hour << 2) + minute
   function automatic logic [DAYMIN_W-1:0] day_minutes(
      input logic [HOUR_W-1:0]   hour,
      input logic [MINUTE_W-1:0] minute
   );
      logic [DAYMIN_W-1:0] h64;
      logic [DAYMIN_W-1:0] h4;
      h64 = {hour, 6'b000000};
      h4  = {4'b0000, hour, 2'b00};
      return h64 - h4 + {{(DAYMIN_W-MINUTE_W){1'b0}}, minute};
   endfunction

endpackage

// ===== hdl/tws_chan_if.sv =====
// tws_chan_if: valid/ready channel carrying one payload per transaction
// payload type given by the user, typically from tws_pkg

interface tws_chan_if #(
   parameter type data_type = logic
);
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/tws_window_unit.sv =====
// tws_window_unit: shared time compare unit (start <= end, start < now <= end)
// depends on tws_pkg

module tws_window_unit
   import tws_pkg::*;
(
   input  logic [HOUR_W-1:0]   now_hour,
   input  logic [MINUTE_W-1:0] now_minute,
   input  window_type          window,
   output cmp_type             result
);

   logic [DAYMIN_W-1:0] now_min;
   logic [DAYMIN_W-1:0] start_min;
   logic [DAYMIN_W-1:0] end_min;

   assign now_min   = day_minutes(now_hour, now_minute);
   assign start_min = day_minutes(window.start_hour, window.start_minute);
   assign end_min   = day_minutes(window.end_hour, window.end_minute);

   assign result.ordered   = (start_min <= end_min);
   assign result.in_window = (start_min < now_min) && (now_min <= end_min);

endmodule

// ===== hdl/time_window_schedule_table.sv =====
// time_window_schedule_table: top level with window memory, scan sequencer and result register
// depends on tws_pkg, tws_chan_if and tws_window_unit
//
//   channel   direction  transaction contents
//   req_bus   in         command, hour, minute, end_hour, end_minute, window_state
//   rsp_bus   out        output_on, stored
//
// store: accept, check and write, result
// query: accept, scan of the filled entries, result; one memory read per cycle
// through the shared compare unit
// reset is synchronous and empties the table; window memory itself is not cleared
// req_bus is ready only between transactions; a result waiting on rsp_bus
// holds the next result back but not the next accept

module time_window_schedule_table
   import tws_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
)(
   input  logic        clock,
   input  logic        reset,
   tws_chan_if.sink    req_bus,
   tws_chan_if.source  rsp_bus
);

   localparam int PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   state_type        state_ff,    state_in;
   req_type          item_ff,     item_in;
   logic [PTR_W-1:0] wr_ptr_ff,   wr_ptr_in;
   logic [CNT_W-1:0] filled_ff,   filled_in;
   logic [CNT_W-1:0] idx_ff,      idx_in;
   logic             pend_ff,     pend_in;
   logic             result_ff,   result_in;
   logic             stored_ff,   stored_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   window_type       rd_data_ff;

   window_type       mem [ENTRIES];
   logic             mem_we;
   logic [PTR_W-1:0] rd_addr;
   window_type       item_window;
   window_type       unit_window;
   cmp_type          cmp;

   assign item_window.start_hour   = item_ff.hour;
   assign item_window.start_minute = item_ff.minute;
   assign item_window.end_hour     = item_ff.end_hour;
   assign item_window.end_minute   = item_ff.end_minute;
   assign item_window.state        = item_ff.window_state;

   assign unit_window = (state_ff == ST_SCAN) ? rd_data_ff : item_window;

   tws_window_unit u_window_unit (
      .now_hour   (item_ff.hour),
      .now_minute (item_ff.minute),
      .window     (unit_window),
      .result     (cmp)
   );

   // window memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ptr_ff] <= item_window;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         filled_ff    <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         filled_ff    <= filled_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      result_ff   <= result_in;
      stored_ff   <= stored_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      wr_ptr_in    = wr_ptr_ff;
      filled_in    = filled_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      result_in    = result_ff;
      stored_in    = stored_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      rd_addr      = idx_ff[PTR_W-1:0];

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               item_in   = req_bus.data;
               result_in = 1'b1;
               stored_in = 1'b0;
               idx_in    = '0;
               pend_in   = 1'b0;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (item_ff.command == CMD_STORE) begin
               if (cmp.ordered) begin
                  mem_we    = 1'b1;
                  stored_in = 1'b1;
                  wr_ptr_in = (wr_ptr_ff == PTR_W'(ENTRIES - 1)) ? '0 : wr_ptr_ff + 1'b1;
                  if (filled_ff != CNT_W'(ENTRIES)) begin
                     filled_in = filled_ff + 1'b1;
                  end
               end
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read of entry idx overlaps the compare of the previous entry
            if (idx_ff < filled_ff) begin
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && cmp.in_window) begin
               result_in = rd_data_ff.state;
            end
            if ((idx_ff == filled_ff) && !pend_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.output_on = (item_ff.command == CMD_STORE) ? 1'b0 : result_ff;
               rsp_data_in.stored    = stored_ff;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CNT_W'(ENTRIES))
      else $error("filled count above table size");

   a_ptr_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      (filled_ff != CNT_W'(ENTRIES)) |-> (wr_ptr_ff == filled_ff[PTR_W-1:0]))
      else $error("write pointer out of step with filled count");

   a_scan_reads_filled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && pend_ff) |-> (filled_ff != '0) && (idx_ff <= filled_ff))
      else $error("scan compared an entry that is not filled");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending result overwritten or dropped");

endmodule

// ===== tb/tb_time_window_schedule_table.sv =====
`timescale 1ns / 100ps
// tb_time_window_schedule_table: self-checking bench for the daily time window table
// depends on tws_pkg, tws_chan_if and time_window_schedule_table; a directed table
// of transactions, then random store/query traffic checked against a window predictor

module tb_time_window_schedule_table;
   import tws_pkg::*;

   localparam int SLOTS          = ENTRIES_DEFAULT;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int PHASE_ITEMS    = 626;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   tws_chan_if #(.data_type(req_type)) req_bus ();
   tws_chan_if #(.data_type(rsp_type)) rsp_bus ();

   time_window_schedule_table #(.ENTRIES(SLOTS)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   window_type sched_windows [SLOTS];
   int         next_slot;
   int         windows_filled;
   rsp_type    pending_verdicts [$];
   rsp_type    oldest_verdict;
   int         error_count;
   int         quiet_cycles;
   int         snd_idle_pct;
   int         rcv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int day_min(logic [HOUR_W-1:0] h, logic [MINUTE_W-1:0] m);
      return int'(h) * 60 + int'(m);
   endfunction

   // updates the predicted table and returns the verdict of one transaction
   function automatic rsp_type predict_schedule(req_type r);
      rsp_type v;
      int      now_min;
      int      i;
      v = '0;
      if (r.command == CMD_STORE) begin
         if (day_min(r.hour, r.minute) <= day_min(r.end_hour, r.end_minute)) begin
            sched_windows[next_slot] = '{r.hour, r.minute, r.end_hour, r.end_minute,
                                         r.window_state};
            next_slot = (next_slot + 1) % SLOTS;
            if (windows_filled < SLOTS) windows_filled++;
            v.stored = 1'b1;
         end
      end else begin
         now_min     = day_min(r.hour, r.minute);
         v.output_on = 1'b1;
         for (i = 0; i < windows_filled; i++) begin
            if (day_min(sched_windows[i].start_hour, sched_windows[i].start_minute) < now_min &&
                now_min <= day_min(sched_windows[i].end_hour, sched_windows[i].end_minute))
               v.output_on = sched_windows[i].state;
         end
      end
      return v;
   endfunction

   function automatic stim_row_type mk_row(logic cmd, int h, int m, int eh, int em, logic st,
                                           bit typed, logic want_on, logic want_stored);
      stim_row_type row;
      row.item.command      = cmd;
      row.item.hour         = h[HOUR_W-1:0];
      row.item.minute       = m[MINUTE_W-1:0];
      row.item.end_hour     = eh[HOUR_W-1:0];
      row.item.end_minute   = em[MINUTE_W-1:0];
      row.item.window_state = st;
      row.typed             = typed;
      row.want.output_on    = want_on;
      row.want.stored       = want_stored;
      return row;
   endfunction

   // mostly legal clock times, sometimes the full field range
   function automatic void rand_time(output logic [HOUR_W-1:0] h,
                                     output logic [MINUTE_W-1:0] m);
      if ($urandom_range(99) < 85) begin
         h = HOUR_W'($urandom_range(23));
         m = MINUTE_W'($urandom_range(59));
      end else begin
         h = HOUR_W'($urandom_range(31));
         m = MINUTE_W'($urandom_range(63));
      end
   endfunction

   function automatic req_type random_item();
      req_type                 r;
      logic [HOUR_W-1:0]       th;
      logic [MINUTE_W-1:0]     tm;
      int                      k;
      int                      mins;
      int                      hh;
      r              = '0;
      r.window_state = 1'($urandom_range(1));
      if ($urandom_range(99) < 40) begin
         r.command = CMD_STORE;
         rand_time(r.hour, r.minute);
         rand_time(r.end_hour, r.end_minute);
         if ($urandom_range(99) < 85 &&
             day_min(r.hour, r.minute) > day_min(r.end_hour, r.end_minute)) begin
            th = r.hour;  tm = r.minute;
            r.hour = r.end_hour;  r.minute = r.end_minute;
            r.end_hour = th;  r.end_minute = tm;
         end
         if ($urandom_range(99) < 5) begin
            r.end_hour   = r.hour;
            r.end_minute = r.minute;
         end
      end else begin
         r.command    = CMD_QUERY;
         r.end_hour   = HOUR_W'($urandom_range(31));
         r.end_minute = MINUTE_W'($urandom_range(63));
         if (windows_filled > 0 && $urandom_range(99) < 55) begin
            // land on or next to a window edge
            k = int'($urandom_range(windows_filled - 1));
            if ($urandom_range(1) == 0)
               mins = day_min(sched_windows[k].start_hour, sched_windows[k].start_minute);
            else
               mins = day_min(sched_windows[k].end_hour, sched_windows[k].end_minute);
            mins = mins + int'($urandom_range(2)) - 1;
            if (mins < 0) mins = 0;
            hh = mins / 60;
            if (hh > 31) hh = 31;
            mins = mins - hh * 60;
            if (mins > 63) mins = 63;
            r.hour   = hh[HOUR_W-1:0];
            r.minute = mins[MINUTE_W-1:0];
         end else begin
            rand_time(r.hour, r.minute);
         end
      end
      return r;
   endfunction

   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      rsp_type v;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= item;
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
      v = predict_schedule(item);
      pending_verdicts.push_back(typed ? want : v);
   endtask

   task automatic wait_all_results();
      req_bus.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= rcv_idle_pct);
   end

   // result checking and watchdog, sampled mid-cycle where everything is settled
   always @(negedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_verdicts.size() == 0) begin
               error_count++;
               $display("%0t: unexpected transaction on rsp_bus, actual %b", $time,
                        rsp_bus.data);
            end else begin
               oldest_verdict = pending_verdicts.pop_front();
               if (rsp_bus.data.output_on !== oldest_verdict.output_on) begin
                  error_count++;
                  $display("%0t: output_on mismatch, expected %b actual %b", $time,
                           oldest_verdict.output_on, rsp_bus.data.output_on);
               end
               if (rsp_bus.data.stored !== oldest_verdict.stored) begin
                  error_count++;
                  $display("%0t: stored mismatch, expected %b actual %b", $time,
                           oldest_verdict.stored, rsp_bus.data.stored);
               end
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("time_window_schedule_table verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      stim_row_type rows [$];
      int           phase;
      int           n;
      req_bus.valid  <= 1'b0;
      req_bus.data   <= '0;
      reset          <= 1'b1;
      next_slot      = 0;
      windows_filled = 0;
      error_count    = 0;
      quiet_cycles   = 0;
      snd_idle_pct   = 19;
      rcv_idle_pct   = 65;

      // empty table answers on
      rows.push_back(mk_row(CMD_QUERY,  0,  0,  0,  0, 1'b0, 1, 1'b1, 1'b0));
      rows.push_back(mk_row(CMD_QUERY, 23, 59, 31, 63, 1'b1, 1, 1'b1, 1'b0));
      rows.push_back(mk_row(CMD_STORE,  8,  0, 17, 30, 1'b0, 1, 1'b0, 1'b1));
      // start after end is rejected
      rows.push_back(mk_row(CMD_STORE, 17, 30,  8,  0, 1'b1, 1, 1'b0, 1'b0));
      rows.push_back(mk_row(CMD_QUERY, 12,  0,  0,  0, 1'b0, 0, 1'b0, 1'b0));
      rows.push_back(mk_row(CMD_QUERY,  8,  0,  0,  0, 1'b0, 0, 1'b0, 1'b0));
      rows.push_back(mk_row(CMD_QUERY, 17, 30,  0,  0, 1'b0, 0, 1'b0, 1'b0));
      // zero length window is kept but never matches
      rows.push_back(mk_row(CMD_STORE, 12,  0, 12,  0, 1'b1, 1, 1'b0, 1'b1));
      rows.push_back(mk_row(CMD_QUERY, 12,  0,  0,  0, 1'b0, 0, 1'b0, 1'b0));
      rows.push_back(mk_row(CMD_STORE, 10,  0, 14,  0, 1'b1, 1, 1'b0, 1'b1));
      rows.push_back(mk_row(CMD_QUERY, 12,  0,  0,  0, 1'b0, 0, 1'b0, 1'b0));
      rows.push_back(mk_row(CMD_STORE,  0,  0, 23, 59, 1'b0, 1, 1'b0, 1'b1));
      rows.push_back(mk_row(CMD_QUERY,  0,  0,  0,  0, 1'b0, 0, 1'b0, 1'b0));
      rows.push_back(mk_row(CMD_QUERY,  0,  1,  0,  0, 1'b0, 0, 1'b0, 1'b0));
      // out of range hours and minutes used as given
      rows.push_back(mk_row(CMD_STORE, 31, 63, 31, 63, 1'b1, 1, 1'b0, 1'b1));
      rows.push_back(mk_row(CMD_STORE, 24,  0, 31, 63, 1'b0, 1, 1'b0, 1'b1));
      rows.push_back(mk_row(CMD_QUERY, 30,  0,  0,  0, 1'b0, 0, 1'b0, 1'b0));
      // end fields and state ignored on a query
      rows.push_back(mk_row(CMD_QUERY, 31, 63, 31, 63, 1'b1, 0, 1'b0, 1'b0));
      rows.push_back(mk_row(CMD_STORE, 23, 59, 24,  0, 1'b1, 1, 1'b0, 1'b1));
      rows.push_back(mk_row(CMD_QUERY, 24,  0,  0,  0, 1'b0, 0, 1'b0, 1'b0));
      rows.push_back(mk_row(CMD_STORE,  0,  1,  0,  0, 1'b1, 1, 1'b0, 1'b0));
      rows.push_back(mk_row(CMD_STORE, 31, 63,  0,  0, 1'b1, 1, 1'b0, 1'b0));
      rows.push_back(mk_row(CMD_QUERY,  5, 63,  0,  0, 1'b0, 0, 1'b0, 1'b0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[n]) send_item(rows[n].item, rows[n].typed, rows[n].want);
      wait_all_results();

      for (phase = 0; phase < 3; phase++) begin
         snd_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 65 : 0;
         rcv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 19 : 0;
         for (n = 0; n < PHASE_ITEMS; n++) send_item(random_item(), 1'b0, '0);
         wait_all_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         error_count++;
         $display("%0t: %0d transactions never answered", $time, pending_verdicts.size());
      end
      if (error_count == 0)
         $display("time_window_schedule_table verification clean");
      else
         $display("time_window_schedule_table verification failed");
      $finish;
   end

endmodule
